@@ design/string_hash_partitioner_macros.svh @@
// Assertion macros for the string hash partitioner RTL.
// Included by shp_back, the module that carries concurrent assertions; no other dependencies.
`ifndef STRING_HASH_PARTITIONER_MACROS_SVH
`define STRING_HASH_PARTITIONER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/shp_pkg.sv @@
// Shared types and constants for the string hash partitioner.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package shp_pkg;

    // djb2 hash constants.
    localparam logic [31:0] HASH_SEED  = 32'd5381;
    localparam int          HASH_SHIFT = 5;

    // Configuration register map.
    localparam int          CFG_ADDR_W    = 3;
    localparam logic        REG_WORKERS   = 1'b0;
    localparam logic [15:0] WORKERS_RESET = 16'd1;

    // Queue between the hashing front and the modulo back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Restoring divider: one quotient bit per cycle over the 32-bit hash.
    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // One finished key waiting for its modulo.
    typedef struct packed {
        logic [31:0] hash;
        logic [15:0] workers;
    } shp_entry_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } shp_state_t;

endpackage

`default_nettype wire

@@ design/shp_front.sv @@
// Front end: folds one key byte per item into the running djb2 hash.
// Depends on shp_pkg; pushes finished keys into shp_queue.
`default_nettype none

module shp_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         key_byte,
    input  wire logic               end_of_key,
    input  wire logic [15:0]        workers,
    input  wire logic               q_full,
    output logic                    push,
    output shp_pkg::shp_entry_t     push_entry
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic        accept;

    // Items are held off only while the queue has no room.
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // hash * 33 + byte, wrapping at 32 bits.
    assign hash_next = (hash_reg << shp_pkg::HASH_SHIFT) + hash_reg + {24'd0, key_byte};

    // The last byte of a key hands the hash and the modulus to the queue.
    assign push               = accept && end_of_key;
    assign push_entry.hash    = hash_next;
    assign push_entry.workers = workers;

    // Running hash, reloaded with the seed after each key.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= shp_pkg::HASH_SEED;
        end
        else if (accept)
        begin
            hash_reg <= end_of_key ? shp_pkg::HASH_SEED : hash_next;
        end
    end

endmodule

`default_nettype wire

@@ design/shp_queue.sv @@
// Short first-in first-out queue of finished keys between front and back.
// Depends on shp_pkg for the entry type and the depth.
`default_nettype none

module shp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire shp_pkg::shp_entry_t push_entry,
    input  wire logic                pop,
    output logic                     full,
    output logic                     empty,
    output shp_pkg::shp_entry_t      head
);

    shp_pkg::shp_entry_t                entry_reg [shp_pkg::QUEUE_DEPTH];
    logic [shp_pkg::QUEUE_AW-1:0]       wr_ptr_reg;
    logic [shp_pkg::QUEUE_AW-1:0]       rd_ptr_reg;
    logic [shp_pkg::QUEUE_CW-1:0]       count_reg;
    logic                               do_push;
    logic                               do_pop;

    assign full    = (count_reg == shp_pkg::QUEUE_CW'(shp_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/shp_back.sv @@
// Back end: reduces each queued hash modulo the worker count with a
// bit-serial restoring divider and holds the bucket in an output register.
// Depends on shp_pkg and on the assertion macros header.
`default_nettype none
`include "string_hash_partitioner_macros.svh"

module shp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire shp_pkg::shp_entry_t head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [15:0]              bucket
);

    shp_pkg::shp_state_t            state_reg;
    shp_pkg::shp_state_t            state_next;
    logic [31:0]                    dvd_reg;
    logic [15:0]                    div_reg;
    logic [15:0]                    rem_reg;
    logic [shp_pkg::DIV_CW-1:0]     cnt_reg;
    logic                           out_valid_reg;
    logic [15:0]                    bucket_reg;
    logic                           out_free;
    logic                           step;
    logic                           load_out;
    logic                           last_step;
    logic [16:0]                    rem_shift;
    logic [16:0]                    rem_next;

    // The output register can take a new bucket when empty or being drained.
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_step = (cnt_reg == shp_pkg::DIV_CW'(shp_pkg::DIV_STEPS - 1));

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            shp_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = shp_pkg::ST_DIV;
                end
            end
            shp_pkg::ST_DIV:
            begin
                if (last_step)
                begin
                    state_next = shp_pkg::ST_DONE;
                end
            end
            shp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = shp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = shp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        pop      = 1'b0;
        step     = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            shp_pkg::ST_IDLE: pop      = !q_empty;
            shp_pkg::ST_DIV:  step     = 1'b1;
            shp_pkg::ST_DONE: load_out = out_free;
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // One restoring division step: bring down the next dividend bit.
    assign rem_shift = {rem_reg, dvd_reg[31]};
    assign rem_next  = (rem_shift >= {1'b0, div_reg}) ? (rem_shift - {1'b0, div_reg})
                                                       : rem_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Divider datapath.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dvd_reg <= head.hash;
            div_reg <= head.workers;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (step)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next[15:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Output register; a zero worker count gives bucket zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            bucket_reg <= (div_reg == '0) ? 16'd0 : rem_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign bucket    = bucket_reg;

    // The partial remainder stays below a nonzero divisor at every step.
    `SHP_ASSERT_IMP(a_rem_below_div, clk, rst_n,
        (state_reg == shp_pkg::ST_DIV) && (div_reg != '0), rem_reg < div_reg)
    // A new bucket never overwrites one the receiver has not taken.
    `SHP_ASSERT_IMP(a_no_overwrite, clk, rst_n,
        load_out, !(out_valid_reg && out_stall))
    // Popping a key always starts a division.
    `SHP_ASSERT_NXT(a_pop_starts_div, clk, rst_n,
        pop, (state_reg == shp_pkg::ST_DIV) && (cnt_reg == '0))

endmodule

`default_nettype wire

@@ design/string_hash_partitioner.sv @@
// Top level of the string hash partitioner: APB register, front, queue, back.
// Depends on shp_pkg, shp_front, shp_queue and shp_back.
//
// Usage: keys arrive one byte per item on the input channel (in_valid,
// in_stall, key_byte, end_of_key). The front folds each byte into a djb2
// hash and takes one byte per cycle while the queue has room. On the byte
// marked end_of_key the hash and the current worker count enter a four-entry
// queue, and the hash is reloaded with 5381. The back pops one key at a
// time and divides with a one-bit-per-cycle restoring divider; the bucket
// (hash modulo the worker count, zero when the worker count is zero) is
// registered onto the output channel (out_valid, out_stall, bucket). The
// divider sets the sustained rate: the back pops a new key only once the
// last bucket is loaded. Bytes stream at one per cycle while the queue has
// room; in_stall rises when four keys are waiting. When the receiver
// stalls, the bucket holds in the output register, the back finishes its
// current division and waits, and the queue then fills. Reset clears the
// queue and output valid, loads the seed into the hash and sets the worker
// count to one. The worker count is written over APB at byte address 0.
`default_nettype none

module string_hash_partitioner (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [shp_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     key_byte,
    input  wire logic                           end_of_key,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [15:0]                         bucket
);

    logic [15:0]          workers_reg;
    logic                 reg_sel;
    logic                 q_full;
    logic                 q_empty;
    logic                 push;
    logic                 pop;
    shp_pkg::shp_entry_t  push_entry;
    shp_pkg::shp_entry_t  head;

    // Configuration register, word index taken from the address.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == shp_pkg::REG_WORKERS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            workers_reg <= shp_pkg::WORKERS_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            workers_reg <= pwdata[15:0];
        end
    end

    assign prdata = reg_sel ? {16'd0, workers_reg} : 32'd0;

    // Hashing front.
    shp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_byte   (key_byte),
        .end_of_key (end_of_key),
        .workers    (workers_reg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue of finished keys.
    shp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    // Modulo back end and output register.
    shp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bucket    (bucket)
    );

endmodule

`default_nettype wire

@@ tb/string_hash_partitioner_test.sv @@
// Self-checking testbench for string_hash_partitioner: a directed table, then random keys.
// Depends on shp_pkg and the string_hash_partitioner RTL only.
// Buckets are predicted by an in-bench djb2 model and checked in order as they arrive.
`default_nettype none

module string_hash_partitioner_test;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 50;
    localparam int PREDICT       = -1;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_BYTES   = 81;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [shp_pkg::CFG_ADDR_W-1:0] WORKERS_ADDR = {shp_pkg::REG_WORKERS, 2'b00};

    typedef enum logic {
        ROW_BYTE,
        ROW_WRITE
    } row_kind_t;

    // One step of the directed part: a key byte or a register write.
    typedef struct {
        row_kind_t   kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] wdata;
        int          want;
    } step_row_t;

    localparam int DIRECTED_ROWS = 23;

    // Fixed expectations appear only where they follow directly from the djb2 seed.
    step_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_BYTE,  8'h41, 1'b1, 32'd0,          0},        // one-byte key, workers = 1
        '{ROW_BYTE,  8'h00, 1'b0, 32'd0,          PREDICT},  // zero byte inside a key
        '{ROW_BYTE,  8'hFF, 1'b1, 32'd0,          0},
        '{ROW_WRITE, 8'h00, 1'b0, 32'd0,          PREDICT},  // zero workers
        '{ROW_BYTE,  8'hFF, 1'b0, 32'd0,          PREDICT},
        '{ROW_BYTE,  8'h01, 1'b1, 32'd0,          0},
        '{ROW_WRITE, 8'h00, 1'b0, 32'h0000_FFFF,  PREDICT},  // largest modulus
        '{ROW_BYTE,  8'h01, 1'b1, 32'd0,          46504},
        '{ROW_BYTE,  8'hFF, 1'b1, 32'd0,          46758},
        '{ROW_BYTE,  8'h00, 1'b1, 32'd0,          46503},    // key made of one zero byte
        '{ROW_BYTE,  8'h61, 1'b0, 32'd0,          PREDICT},
        '{ROW_WRITE, 8'h00, 1'b0, 32'd7,          PREDICT},  // modulus changed mid-key
        '{ROW_BYTE,  8'h62, 1'b1, 32'd0,          PREDICT},
        '{ROW_BYTE,  8'h80, 1'b0, 32'd0,          PREDICT},
        '{ROW_BYTE,  8'h7F, 1'b0, 32'd0,          PREDICT},
        '{ROW_BYTE,  8'hAA, 1'b0, 32'd0,          PREDICT},
        '{ROW_BYTE,  8'h55, 1'b1, 32'd0,          PREDICT},
        '{ROW_WRITE, 8'h00, 1'b0, 32'hABCD_03E8,  PREDICT},  // upper data bits ignored
        '{ROW_BYTE,  8'hFF, 1'b0, 32'd0,          PREDICT},  // long key wraps the hash
        '{ROW_BYTE,  8'hFF, 1'b0, 32'd0,          PREDICT},
        '{ROW_BYTE,  8'hFF, 1'b0, 32'd0,          PREDICT},
        '{ROW_BYTE,  8'hFF, 1'b0, 32'd0,          PREDICT},
        '{ROW_BYTE,  8'hFF, 1'b1, 32'd0,          PREDICT}
    };

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [shp_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata     = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        in_valid   = 1'b0;
    wire         in_stall;
    logic [7:0]  key_byte   = 8'h00;
    logic        end_of_key = 1'b0;
    wire         out_valid;
    logic        out_stall  = 1'b0;
    wire  [15:0] bucket;

    // Shadow state of the djb2 predictor.
    logic [31:0] hash_acc    = shp_pkg::HASH_SEED;
    logic [15:0] workers_cfg = shp_pkg::WORKERS_RESET;
    logic [15:0] bucket_q[$];

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int cycle_count    = 0;
    int error_count    = 0;
    int bytes_sent     = 0;
    int keys_sent      = 0;
    int buckets_seen   = 0;
    int writes_done    = 0;

    string_hash_partitioner uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_byte   (key_byte),
        .end_of_key (end_of_key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bucket     (bucket)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d buckets pending.",
                     cycle_count, bucket_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic log_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    // Fold one accepted byte into the shadow hash; a final byte yields the bucket.
    task automatic fold_key_byte(input logic [7:0] data, input logic last, input int fixed);
        logic [15:0] predicted;
        hash_acc = (hash_acc << shp_pkg::HASH_SHIFT) + hash_acc + {24'd0, data};
        bytes_sent++;
        if (last)
        begin
            predicted = (workers_cfg != 16'd0) ? 16'(hash_acc % {16'd0, workers_cfg}) : 16'd0;
            bucket_q.push_back((fixed == PREDICT) ? predicted : 16'(fixed));
            hash_acc = shp_pkg::HASH_SEED;
            keys_sent++;
        end
    endtask

    // Check each accepted bucket against the oldest expectation.
    always @(posedge clk)
    begin
        logic [15:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            buckets_seen++;
            if (bucket_q.size() == 0)
            begin
                log_failure($sformatf("Unexpected bucket %0d at cycle %0d",
                                      bucket, cycle_count));
            end
            else
            begin
                want = bucket_q.pop_front();
                if (bucket !== want)
                    log_failure($sformatf("Bucket mismatch at cycle %0d: expected %0d, got %0d",
                                          cycle_count, want, bucket));
            end
        end
    end

    // Offer one byte after a random gap and hold it until it is taken.
    task automatic send_key_byte(input logic [7:0] data, input logic last, input int fixed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid   <= 1'b0;
            key_byte   <= 8'($urandom);
            end_of_key <= 1'($urandom);
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        key_byte   <= data;
        end_of_key <= last;
        do
            @(posedge clk);
        while (in_stall);
        fold_key_byte(data, last, fixed);
    endtask

    // Stop offering items, let every bucket come back, then allow for the divider.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (bucket_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup phase, then access phase until pready.
    task automatic write_workers(input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= WORKERS_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        workers_cfg = value[15:0];
        writes_done++;
    endtask

    initial
    begin
        int          phase_bytes;
        int          key_len;
        logic [7:0]  data;
        logic [31:0] wdata;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                wait_until_drained();
                write_workers(directed_rows[r].wdata);
            end
            else
            begin
                send_key_byte(directed_rows[r].data, directed_rows[r].last,
                              directed_rows[r].want);
            end
        end

        // Random keys, one modulus and one idle mix per phase.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_until_drained();
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 63;
                end
                default:
                begin
                    send_idle_pct = 34;
                    stall_pct     = 34;
                end
            endcase
            case (ph)
                0: wdata = 32'd3;
                1: wdata = $urandom;
                2: wdata = 32'h0000_FFFF;
                3: wdata = $urandom_range(2, 40);
                4: wdata = 32'd0;
                5: wdata = 32'd1;
                6: wdata = {16'($urandom), 16'($urandom_range(1000, 65535))};
                default: wdata = 32'd256;
            endcase
            write_workers(wdata);

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                // Mostly short keys; now and then a long one to wrap the hash many times.
                key_len = ($urandom_range(9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(1, 5);
                for (int j = 0; j < key_len; j++)
                begin
                    data = ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
                    send_key_byte(data, (j == key_len - 1), PREDICT);
                end
                phase_bytes += key_len;
            end
        end

        wait_until_drained();
        stall_pct = 0;
        if (bucket_q.size() != 0)
            log_failure($sformatf("%0d buckets never arrived", bucket_q.size()));

        $display("Summary: %0d bytes in %0d keys, %0d buckets checked, %0d register writes.",
                 bytes_sent, keys_sent, buckets_seen, writes_done);
        $display("Moduli ranged over zero, one, small, random and full scale; %0d errors.",
                 error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/shp_pkg.sv
design/shp_front.sv
design/shp_queue.sv
design/shp_back.sv
design/string_hash_partitioner.sv
tb/string_hash_partitioner_test.sv
